/* sv/glb_pkg.sv */
// ----------------------------------------------------------------------------
// glb_pkg
// shared constants and types for the glyph bitmap blitter
// ----------------------------------------------------------------------------
package glb_pkg;

    // display geometry
    localparam int COLUMNS          = 256;
    localparam int BYTES_PER_COLUMN = 16;

    // framebuffer store
    localparam int STORE_DEPTH = 4096;
    localparam int ADDR_W      = 12;

    // item kinds
    localparam logic [1:0] KIND_GLYPH = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;

    // store write port
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } ram_wr_t;

    // store read port
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } ram_rd_t;

    // pixel placement from the pixel address unit
    typedef struct packed {
        logic              hit;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        mask;
    } pix_t;

endpackage

/* sv/glyph_bitmap_blitter_unit.sv */
// ----------------------------------------------------------------------------
// glyph_bitmap_blitter_unit
// column-major monochrome framebuffer with glyph blit and host byte access
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid / in_ready) carries one item per transfer:
//   a glyph byte, a framebuffer byte read or a framebuffer byte write
//   output channel (out_valid / out_ready) returns read_byte for read items
// order of events
//   write: the byte lands at the accepting edge
//   read: the store's registered read port, then the output register
//   glyph byte: each of its eight bits is one visit of the pixel address
//   unit; a clipped or unused bit needs no store access, a visible one adds
//   a read-modify-write on the store port; new items wait until the walk ends
// reset
//   after rst_n rises a clearing pass writes white (0xFF) into all 4096
//   store bytes, one a cycle, so the block is not ready until the pass ends
// stall
//   a finished read waits in the output register; further writes and glyph
//   bytes are still taken, a new read waits until the register is free
// ----------------------------------------------------------------------------
module glyph_bitmap_blitter_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  kind,
    input  logic                        glyph_start,
    input  logic [7:0]                  glyph_byte,
    input  logic signed [9:0]           origin_x,
    input  logic signed [9:0]           origin_y,
    input  logic [7:0]                  glyph_width,
    input  logic [7:0]                  glyph_height,
    input  logic [glb_pkg::ADDR_W-1:0]  byte_address,
    input  logic [7:0]                  write_byte,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [7:0]                  read_byte
);

    typedef enum logic [4:0] {
        ST_CLEAR   = 5'b00001,
        ST_IDLE    = 5'b00010,
        ST_RD_DONE = 5'b00100,
        ST_BIT     = 5'b01000,
        ST_WR      = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // clearing pass address
    logic [glb_pkg::ADDR_W-1:0] clr_addr_reg, clr_addr_next;

    // glyph item held for the bit walk
    logic [7:0]        bits_reg, bits_next;
    logic signed [9:0] ox_reg, ox_next;
    logic signed [9:0] oy_reg, oy_next;
    logic [7:0]        w_reg, w_next;
    logic [15:0]       total_reg, total_next;
    logic [2:0]        idx_reg, idx_next;

    // glyph position counters, kept across items
    logic [15:0] count_reg, count_next;
    logic [7:0]  col_reg, col_next;
    logic [7:0]  row_reg, row_next;

    // pending read-modify-write
    logic [glb_pkg::ADDR_W-1:0] wr_addr_reg, wr_addr_next;
    logic [7:0]                 mask_reg, mask_next;
    logic                       black_reg, black_next;

    // output register
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_data_reg, out_data_next;

    logic             accept;
    logic             wrap;
    logic [7:0]       col_eff;
    logic [7:0]       row_eff;
    logic [7:0]       rd_data;
    glb_pkg::pix_t    pix;
    glb_pkg::ram_wr_t ram_wr;
    glb_pkg::ram_rd_t ram_rd;

    // besides the idle state, a read also waits while the output register is full and not being emptied
    assign in_ready = (state_reg == ST_IDLE)
                   && (!out_valid_reg || out_ready || (kind != glb_pkg::KIND_READ));
    assign accept   = in_valid && in_ready;

    // column wraps to the next row when it runs past the width
    assign wrap    = (col_reg >= w_reg);
    assign col_eff = wrap ? 8'd0 : col_reg;
    assign row_eff = wrap ? row_reg + 8'd1 : row_reg;

    glb_pixel_unit u_pixel (
        .origin_x (ox_reg),
        .origin_y (oy_reg),
        .col      (col_eff),
        .row      (row_eff),
        .pix      (pix)
    );

    glb_frame_ram u_ram (
        .clk     (clk),
        .wr      (ram_wr),
        .rd      (ram_rd),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        bits_next      = bits_reg;
        ox_next        = ox_reg;
        oy_next        = oy_reg;
        w_next         = w_reg;
        total_next     = total_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        wr_addr_next   = wr_addr_reg;
        mask_next      = mask_reg;
        black_next     = black_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        ram_wr         = '0;
        ram_rd         = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                ram_wr.en     = 1'b1;
                ram_wr.addr   = clr_addr_reg;
                ram_wr.data   = 8'hFF;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == glb_pkg::ADDR_W'(glb_pkg::STORE_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    case (kind)
                        glb_pkg::KIND_GLYPH:
                        begin
                            bits_next  = glyph_byte;
                            ox_next    = origin_x;
                            oy_next    = origin_y;
                            w_next     = glyph_width;
                            total_next = {8'd0, glyph_width} * {8'd0, glyph_height};
                            idx_next   = 3'd7;
                            if (glyph_start)
                            begin
                                count_next = '0;
                                col_next   = '0;
                                row_next   = '0;
                            end
                            state_next = ST_BIT;
                        end
                        glb_pkg::KIND_READ:
                        begin
                            ram_rd.en   = 1'b1;
                            ram_rd.addr = byte_address;
                            state_next  = ST_RD_DONE;
                        end
                        glb_pkg::KIND_WRITE:
                        begin
                            ram_wr.en   = 1'b1;
                            ram_wr.addr = byte_address;
                            ram_wr.data = write_byte;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_RD_DONE:
            begin
                out_valid_next = 1'b1;
                out_data_next  = rd_data;
                state_next     = ST_IDLE;
            end

            ST_BIT:
            begin
                if (count_reg >= total_reg)
                begin
                    // glyph complete, rest of the byte is ignored
                    state_next = ST_IDLE;
                end
                else
                begin
                    col_next   = col_eff + 8'd1;
                    row_next   = row_eff;
                    count_next = count_reg + 16'd1;
                    if (pix.hit)
                    begin
                        ram_rd.en    = 1'b1;
                        ram_rd.addr  = pix.addr;
                        wr_addr_next = pix.addr;
                        mask_next    = pix.mask;
                        black_next   = bits_reg[idx_reg];
                        state_next   = ST_WR;
                    end
                    else if (idx_reg == 3'd0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg - 3'd1;
                    end
                end
            end

            ST_WR:
            begin
                ram_wr.en   = 1'b1;
                ram_wr.addr = wr_addr_reg;
                ram_wr.data = black_reg ? (rd_data & ~mask_reg) : (rd_data | mask_reg);
                if (idx_reg == 3'd0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg - 3'd1;
                    state_next = ST_BIT;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            count_reg     <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            count_reg     <= count_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        bits_reg     <= bits_next;
        ox_reg       <= ox_next;
        oy_reg       <= oy_next;
        w_reg        <= w_next;
        total_reg    <= total_next;
        idx_reg      <= idx_next;
        wr_addr_reg  <= wr_addr_next;
        mask_reg     <= mask_next;
        black_reg    <= black_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign read_byte = out_data_reg;

`ifndef SYNTHESIS
    // nothing is taken during the clearing pass
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !in_ready)
        else $error("item taken during clearing pass");

    // a read transfer moves to the result load state in the next cycle
    a_read_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (kind == glb_pkg::KIND_READ)) |=> (state_reg == ST_RD_DONE))
        else $error("read transfer not followed by result load");

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD_DONE) |-> (!out_valid_reg || out_ready))
        else $error("output register overwritten while full");

    // a pixel write always follows its read
    a_wr_after_bit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WR) |-> ($past(state_reg) == ST_BIT))
        else $error("pixel write without preceding read");
`endif

endmodule

/* sv/glb_frame_ram.sv */
// ----------------------------------------------------------------------------
// glb_frame_ram
// framebuffer byte store, one write and one registered read port
// ----------------------------------------------------------------------------
module glb_frame_ram (
    input  logic            clk,
    input  glb_pkg::ram_wr_t wr,
    input  glb_pkg::ram_rd_t rd,
    output logic [7:0]      rd_data
);

    logic [7:0] mem [glb_pkg::STORE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data <= mem[rd.addr];
        end
    end

endmodule

/* sv/glb_pixel_unit.sv */
// ----------------------------------------------------------------------------
// glb_pixel_unit
// maps one glyph pixel to a store byte address and bit mask, with clipping
// ----------------------------------------------------------------------------
module glb_pixel_unit (
    input  logic signed [9:0] origin_x,
    input  logic signed [9:0] origin_y,
    input  logic [7:0]        col,
    input  logic [7:0]        row,
    output glb_pkg::pix_t     pix
);

    localparam int BPC_W  = $clog2(glb_pkg::BYTES_PER_COLUMN + 1);
    localparam int PROD_W = 10 + BPC_W;
    localparam int FULL_W = PROD_W + 2;

    logic signed [10:0] px;
    logic signed [10:0] py;
    logic               px_ok;
    logic               py_ok;
    logic [PROD_W-1:0]  prod;
    logic [FULL_W-1:0]  addr_full;

    assign px = {origin_x[9], origin_x} + $signed({3'b000, col});
    assign py = {origin_y[9], origin_y} + $signed({3'b000, row});

    // sign bit clear and below the display limits
    assign px_ok = !px[10] && ({1'b0, px[9:0]} < 11'(glb_pkg::COLUMNS));
    assign py_ok = !py[10] && ({1'b0, py[9:0]} < 11'(8 * glb_pkg::BYTES_PER_COLUMN));

    assign prod      = PROD_W'(px[9:0]) * PROD_W'(glb_pkg::BYTES_PER_COLUMN);
    assign addr_full = FULL_W'(prod) + FULL_W'(py[9:3]);

    assign pix.hit  = px_ok && py_ok && (addr_full < FULL_W'(glb_pkg::STORE_DEPTH));
    assign pix.addr = addr_full[glb_pkg::ADDR_W-1:0];
    assign pix.mask = 8'h80 >> py[2:0];

endmodule
